>>> hdl/deadline_task_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Deadline task scheduler assertion macros
// Property wrappers shared by the scheduler core: same-cycle and next-cycle
// implications, clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TASK_SCHEDULER_CORE_MACROS_SVH
`define DEADLINE_TASK_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define DTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dts_pkg.sv
// ----------------------------------------------------------------------------
// Deadline task scheduler package
// Field widths, request kinds, policy codes and result status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dts_pkg;

    localparam int FIELD_W  = 16;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic POLICY_EDF = 1'b0;
    localparam logic POLICY_LSF = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RAN      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;

    typedef logic [ID_W-1:0] task_id_t;

endpackage

>>> hdl/deadline_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// Deadline task scheduler core
// Task table in a synchronous memory with valid bits in flip-flops. A tick
// scans the table one slot per cycle for the earliest deadline or least
// slack among arrived tasks, then writes back or retires the chosen task.
// ----------------------------------------------------------------------------
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------
//  request   | start, busy (start&!busy)| req_type, now, arrival_time,
//            |                          | deadline_time, exec_time
//  result    | done strobe, one cycle   | status, task_id, remaining
//  config    | cfg_valid, cfg_ready     | policy_mode
//
//  Add: the valid bits are scanned one slot per cycle until a free slot is found.
//  Tick: one memory read per slot, a last compare, a write-back step and
//  then the result.
//  Reset clears valid bits, sets next id to 1 and policy to EDF; the memory is not cleared.
//  busy is high from accept until the result strobe, except for an add rejected for an
//  exhausted id; results cannot stall.
`timescale 1ns / 1ps

`include "deadline_task_scheduler_core_macros.svh"

module deadline_task_scheduler_core #(
    parameter int TASKS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [dts_pkg::FIELD_W-1:0]         now,
    input  logic [dts_pkg::FIELD_W-1:0]         arrival_time,
    input  logic [dts_pkg::FIELD_W-1:0]         deadline_time,
    input  logic [dts_pkg::FIELD_W-1:0]         exec_time,
    output logic                                done,
    output logic [dts_pkg::STATUS_W-1:0]        status,
    output logic [dts_pkg::ID_W-1:0]            task_id,
    output logic [dts_pkg::FIELD_W-1:0]         remaining,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                policy_mode
);

    localparam int IDX_W  = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int MEM_W  = dts_pkg::ID_W + 3 * TIME_BITS;
    localparam int KEY_W  = TIME_BITS + 2;
    localparam int REM_LO = 0;
    localparam int DL_LO  = TIME_BITS;
    localparam int ARR_LO = 2 * TIME_BITS;
    localparam int ID_LO  = 3 * TIME_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASKS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_TICK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [IDX_W-1:0]              scan_reg, scan_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic [TIME_BITS-1:0]          now_reg, now_next;
    logic [TIME_BITS-1:0]          arr_reg, arr_next;
    logic [TIME_BITS-1:0]          dl_reg, dl_next;
    logic [TIME_BITS-1:0]          ex_reg, ex_next;
    logic                          policy_reg, policy_next;
    dts_pkg::task_id_t             next_id_reg, next_id_next;
    logic [TASKS-1:0]              slot_valid_reg, slot_valid_next;
    logic                          best_found_reg, best_found_next;
    logic signed [KEY_W-1:0]       best_key_reg, best_key_next;
    dts_pkg::task_id_t             best_id_reg, best_id_next;
    logic [IDX_W-1:0]              best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0]          best_arr_reg, best_arr_next;
    logic [TIME_BITS-1:0]          best_dl_reg, best_dl_next;
    logic [TIME_BITS-1:0]          best_rem_reg, best_rem_next;
    logic                          done_reg, done_next;
    logic [dts_pkg::STATUS_W-1:0]  status_reg, status_next;
    dts_pkg::task_id_t             task_id_reg, task_id_next;
    logic [dts_pkg::FIELD_W-1:0]   remaining_reg, remaining_next;

    logic [MEM_W-1:0]              slot_mem [TASKS];
    logic [MEM_W-1:0]              rdata_reg;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [MEM_W-1:0]              mem_wdata;

    dts_pkg::task_id_t             c_id;
    logic [TIME_BITS-1:0]          c_arr;
    logic [TIME_BITS-1:0]          c_dl;
    logic [TIME_BITS-1:0]          c_rem;
    logic signed [KEY_W-1:0]       c_key;
    logic                          c_take;
    logic [TIME_BITS-1:0]          ex_in;
    logic [TIME_BITS-1:0]          rem_dec;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign status    = status_reg;
    assign task_id   = task_id_reg;
    assign remaining = remaining_reg;

    assign c_id  = rdata_reg[ID_LO +: dts_pkg::ID_W];
    assign c_arr = rdata_reg[ARR_LO +: TIME_BITS];
    assign c_dl  = rdata_reg[DL_LO +: TIME_BITS];
    assign c_rem = rdata_reg[REM_LO +: TIME_BITS];

    always_comb
    begin
        if (policy_reg == dts_pkg::POLICY_EDF)
        begin
            c_key = $signed({2'b00, c_dl});
        end
        else
        begin
            c_key = $signed({2'b00, c_dl}) - $signed({2'b00, now_reg})
                    - $signed({2'b00, c_rem});
        end
    end

    assign c_take = cmp_vld_reg && slot_valid_reg[cmp_idx_reg] && (c_arr <= now_reg)
                    && (!best_found_reg || (c_key < best_key_reg)
                        || ((c_key == best_key_reg) && (c_id < best_id_reg)));

    assign ex_in   = (TIME_BITS'(exec_time) == '0) ? TIME_BITS'(1) : TIME_BITS'(exec_time);
    assign rem_dec = best_rem_reg - TIME_BITS'(1);

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        now_next        = now_reg;
        arr_next        = arr_reg;
        dl_next         = dl_reg;
        ex_next         = ex_reg;
        policy_next     = policy_reg;
        next_id_next    = next_id_reg;
        slot_valid_next = slot_valid_reg;
        best_found_next = best_found_reg;
        best_key_next   = best_key_reg;
        best_id_next    = best_id_reg;
        best_idx_next   = best_idx_reg;
        best_arr_next   = best_arr_reg;
        best_dl_next    = best_dl_reg;
        best_rem_next   = best_rem_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        task_id_next    = task_id_reg;
        remaining_next  = remaining_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_reg;
        mem_wdata       = {next_id_reg, arr_reg, dl_reg, ex_reg};

        if (cfg_valid)
        begin
            policy_next = policy_mode;
        end

        // hold the best candidate seen so far
        if (c_take)
        begin
            best_found_next = 1'b1;
            best_key_next   = c_key;
            best_id_next    = c_id;
            best_idx_next   = cmp_idx_reg;
            best_arr_next   = c_arr;
            best_dl_next    = c_dl;
            best_rem_next   = c_rem;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    now_next  = TIME_BITS'(now);
                    arr_next  = TIME_BITS'(arrival_time);
                    dl_next   = TIME_BITS'(deadline_time);
                    ex_next   = ex_in;
                    scan_next = '0;
                    if (req_type == dts_pkg::REQ_TICK)
                    begin
                        best_found_next = 1'b0;
                        state_next      = S_TICK;
                    end
                    else if (next_id_reg == '0)
                    begin
                        done_next      = 1'b1;
                        status_next    = dts_pkg::ST_REJECT;
                        task_id_next   = '0;
                        remaining_next = '0;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                if (!slot_valid_reg[scan_reg])
                begin
                    mem_we                    = 1'b1;
                    slot_valid_next[scan_reg] = 1'b1;
                    next_id_next              = next_id_reg + dts_pkg::ID_W'(1);
                    done_next                 = 1'b1;
                    status_next               = dts_pkg::ST_ADDED;
                    task_id_next              = next_id_reg;
                    remaining_next            = dts_pkg::FIELD_W'(ex_reg);
                    state_next                = S_IDLE;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    done_next      = 1'b1;
                    status_next    = dts_pkg::ST_REJECT;
                    task_id_next   = '0;
                    remaining_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            S_TICK:
            begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_reg;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                mem_waddr  = best_idx_reg;
                mem_wdata  = {best_id_reg, best_arr_reg, best_dl_reg, rem_dec};
                if (!best_found_reg)
                begin
                    status_next    = dts_pkg::ST_IDLE;
                    task_id_next   = '0;
                    remaining_next = '0;
                end
                else if (rem_dec == '0)
                begin
                    slot_valid_next[best_idx_reg] = 1'b0;
                    status_next                   = dts_pkg::ST_FINISHED;
                    task_id_next                  = best_id_reg;
                    remaining_next                = '0;
                end
                else
                begin
                    mem_we         = 1'b1;
                    status_next    = dts_pkg::ST_RAN;
                    task_id_next   = best_id_reg;
                    remaining_next = dts_pkg::FIELD_W'(rem_dec);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= slot_mem[scan_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            policy_reg     <= dts_pkg::POLICY_EDF;
            next_id_reg    <= dts_pkg::ID_W'(1);
            slot_valid_reg <= '0;
            best_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            cmp_vld_reg    <= cmp_vld_next;
            policy_reg     <= policy_next;
            next_id_reg    <= next_id_next;
            slot_valid_reg <= slot_valid_next;
            best_found_reg <= best_found_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        now_reg       <= now_next;
        arr_reg       <= arr_next;
        dl_reg        <= dl_next;
        ex_reg        <= ex_next;
        best_key_reg  <= best_key_next;
        best_id_reg   <= best_id_next;
        best_idx_reg  <= best_idx_next;
        best_arr_reg  <= best_arr_next;
        best_dl_reg   <= best_dl_next;
        best_rem_reg  <= best_rem_next;
        status_reg    <= status_next;
        task_id_reg   <= task_id_next;
        remaining_reg <= remaining_next;
    end

    `DTS_ASSERT_NOW(a_done_when_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "result while busy")
    `DTS_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done_reg, "item lost on accept")
    `DTS_ASSERT_NOW(a_idle_zero, clk, rst_n, done_reg && (status_reg == dts_pkg::ST_IDLE), (task_id_reg == '0) && (remaining_reg == '0), "idle result not zero")
    `DTS_ASSERT_NOW(a_best_valid, clk, rst_n, (state_reg == S_WB) && best_found_reg, slot_valid_reg[best_idx_reg], "chosen slot not valid")

endmodule
